/* rtl/kes_pkg.sv */
package kes_pkg;

	localparam int FRAC_BITS    = 28;
	localparam int CORDIC_STEPS = 30;
	localparam int WORK_BITS    = 60;
	localparam int RED_SHIFT    = WORK_BITS - FRAC_BITS;

	localparam logic [63:0] HALF_PI_Q60    = 64'h1921FB54442D1847;
	localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
	localparam logic signed [63:0] GAIN_Q60 = 64'sd700114967507363239;

	// reduction step h (pi/2 in angle units) and its lost low part in Q60
	localparam logic [63:0] RED_H     = HALF_PI_Q60 >> RED_SHIFT;
	localparam logic [63:0] RED_DELTA = HALF_PI_Q60 - (RED_H << RED_SHIFT);
	localparam logic [63:0] RED_HALF  = RED_H / 2;

	localparam logic [62:0] STEP_CAP = 63'h4000000000000000;

	localparam int DIV_STEPS = 62;

	typedef logic signed [63:0] atan_tab_t [64];

	// atan(2^-i) in Q60: alternating series in Q62 with truncated terms, rounded
	function automatic atan_tab_t atan_table();
		atan_tab_t t;
		logic [63:0] acc;
		logic [63:0] term;
		int ex;
		t[0] = QUARTER_PI_Q60;
		for (int i = 1; i < 64; i++) begin
			acc = 64'd0;
			for (int k = 0; k < 32; k++) begin
				ex = i * (2 * k + 1);
				if (ex <= 62) begin
					term = (64'd1 << (62 - ex)) / 64'(2 * k + 1);
					if (k % 2 == 1) acc = acc - term;
					else acc = acc + term;
				end
			end
			t[i] = (acc + 64'd2) >> 2;
		end
		return t;
	endfunction

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       red;
		logic       zinit;
		logic       cord;
		logic [5:0] cord_idx;
		logic       quad;
		logic       mul;
		logic [2:0] mul_sel;
		logic       resid;
		logic       div;
		logic       div_first;
		logic       upd;
		logic       fin;
	} kes_cmd_t;

	typedef struct packed {
		logic red_done;
		logic div_cap;
		logic conv;
	} kes_sts_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PREP  = 9'b000000010,
		ST_RED   = 9'b000000100,
		ST_CORD  = 9'b000001000,
		ST_QUAD  = 9'b000010000,
		ST_MUL   = 9'b000100000,
		ST_RESID = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} kes_state_t;

	localparam logic [1:0] REG_TOLERANCE = 2'd0;
	localparam logic [1:0] REG_MAX_ITER  = 2'd1;

endpackage

/* rtl/kepler_equation_solver.sv */
// Kepler equation solver: finds E with E - e*sin(E) = M by Newton passes.
// Input stream s_*: one word carries mean_anomaly (signed Q4.28) in bits
// 31:0 and eccentricity (Q0.32) in bits 63:32.
// Output stream m_*: eccentric_anomaly in tdata 31:0, passes_used in 37:32,
// converged flag in tuser.
// Config channel cfg_*: index 0 = tolerance (2^-28 rad units), index 1 =
// max_iterations (zero acts as one). Always ready; write only while idle.
// Each Newton pass: reduction setup, reduction by a quarter turn of the
// angle per step, CORDIC sine/cosine (CORDIC_STEPS steps), quadrant map,
// four 32x32 partial products on one multiplier, residual, restoring
// divide of 62 quotient bits (skipped when the step saturates), update.
// The serial divider dominates the pass time.
// One item is in work at a time; s_tready is high only when idle.
// The finished word waits in an output register, so the next item is taken
// while the receiver stalls; a second result waits until that register frees.
// Reset clears the control state and loads tolerance 268, max_iterations 16.
module kepler_equation_solver #(
	parameter int CORDIC_STEPS = kes_pkg::CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // mean_anomaly[31:0], eccentricity[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // eccentric_anomaly[31:0], passes_used[37:32], zero
	output logic        m_tuser,   // converged
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kes_pkg::*;

	kes_cmd_t           cmd;
	kes_sts_t           sts;
	logic [15:0]        tol_q;
	logic [5:0]         max_iter_q;
	logic signed [31:0] e_out;
	logic [5:0]         passes;
	logic               conv;

	// config registers: always accept, drop writes beyond the list
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= 16'd268;
			max_iter_q <= 6'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOLERANCE: tol_q      <= cfg_data;
				REG_MAX_ITER:  max_iter_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	kes_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.max_iter  (max_iter_q),
		.sts       (sts),
		.cmd       (cmd),
		.passes    (passes),
		.converged (conv)
	);

	kes_dp u_dp (
		.clk               (clk),
		.cmd               (cmd),
		.mean_anomaly      (s_tdata[31:0]),
		.eccentricity      (s_tdata[63:32]),
		.tolerance         (tol_q),
		.sts               (sts),
		.eccentric_anomaly (e_out)
	);

	assign m_tdata = {2'b00, passes, e_out};
	assign m_tuser = conv;

endmodule

/* rtl/kes_ctrl.sv */
module kes_ctrl #(
	parameter int CORDIC_STEPS = kes_pkg::CORDIC_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic [5:0]        max_iter,
	input  kes_pkg::kes_sts_t sts,
	output kes_pkg::kes_cmd_t cmd,
	output logic [5:0]        passes,
	output logic              converged
);
	import kes_pkg::*;

	kes_state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [5:0] pass_q, pass_d;
	logic       conv_q, conv_d;
	logic       oval_q;
	logic [5:0] cap;
	logic       out_free;

	assign cap      = (max_iter == 6'd0) ? 6'd1 : max_iter;
	assign out_free = !oval_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		pass_d  = pass_q;
		conv_d  = conv_q;
		cmd.cord_idx = cnt_q;
		cmd.mul_sel  = cnt_q[2:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pass_d   = 6'd0;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_RED;
			end
			ST_RED: begin
				if (sts.red_done) begin
					cmd.zinit = 1'b1;
					cnt_d     = 6'd0;
					state_d   = ST_CORD;
				end else begin
					cmd.red = 1'b1;
				end
			end
			ST_CORD: begin
				cmd.cord = 1'b1;
				if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
					state_d = ST_QUAD;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_QUAD: begin
				cmd.quad = 1'b1;
				cnt_d    = 6'd0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (cnt_q == 6'd7) begin
					state_d = ST_RESID;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_RESID: begin
				cmd.resid = 1'b1;
				cnt_d     = 6'd0;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_cap || cnt_q == 6'(DIV_STEPS)) begin
					// apply the step and decide whether another pass runs
					cmd.upd = 1'b1;
					pass_d  = pass_q + 6'd1;
					conv_d  = sts.conv;
					if (sts.conv || (pass_q + 6'd1) >= cap) state_d = ST_FIN;
					else state_d = ST_PREP;
				end else begin
					cmd.div       = 1'b1;
					cmd.div_first = (cnt_q == 6'd0);
					cnt_d         = cnt_q + 6'd1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 6'd0;
			pass_q  <= 6'd0;
			conv_q  <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pass_q  <= pass_d;
			conv_q  <= conv_d;
			if (cmd.fin) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			passes    <= pass_q;
			converged <= conv_q;
		end
	end

	assign out_valid = oval_q;

endmodule

/* rtl/kes_dp.sv */
module kes_dp (
	input  logic                clk,
	input  kes_pkg::kes_cmd_t   cmd,
	input  logic signed [31:0]  mean_anomaly,
	input  logic [31:0]         eccentricity,
	input  logic [15:0]         tolerance,
	output kes_pkg::kes_sts_t   sts,
	output logic signed [31:0]  eccentric_anomaly
);
	import kes_pkg::*;

	localparam atan_tab_t ATAN_TAB = atan_table();

	logic signed [31:0] m_q, e_q;
	logic [31:0]        ecc_q;
	logic signed [34:0] r_q;
	logic signed [3:0]  k_q;
	logic signed [63:0] kd_q;
	logic signed [63:0] x_q, y_q, z_q, s_q, c_q;
	logic [63:0]        prod_q;
	logic [95:0]        acc_q;
	logic [32:0]        es_mag_q;
	logic [62:0]        ec_mag_q;
	logic               d_neg_q;
	logic [63:0]        ad_q, den_q, rem_q;
	logic [61:0]        quo_q;
	logic               cap_q;

	logic [63:0]        s_mag, c_mag, mul_op;
	logic [95:0]        acc_sum;
	logic signed [63:0] dx, dy, z_new;
	logic signed [39:0] d_w;
	logic signed [64:0] den_w;
	logic [63:0]        ad_w, rem_sh;
	logic signed [63:0] e_ext, e_new;
	logic [62:0]        step;

	assign s_mag   = s_q[63] ? 64'(-s_q) : 64'(s_q);
	assign c_mag   = c_q[63] ? 64'(-c_q) : 64'(c_q);
	assign acc_sum = acc_q + {prod_q, 32'd0};

	always_comb begin
		case (cmd.mul_sel[2:1])
			2'd0:    mul_op = {32'd0, s_mag[31:0]};
			2'd1:    mul_op = {32'd0, s_mag[63:32]};
			2'd2:    mul_op = {32'd0, c_mag[31:0]};
			default: mul_op = {32'd0, c_mag[63:32]};
		endcase
	end

	assign dx = y_q >>> cmd.cord_idx;
	assign dy = x_q >>> cmd.cord_idx;

	assign d_w   = 40'(e_q) - (s_q[63] ? -40'(es_mag_q) : 40'(es_mag_q)) - 40'(m_q);
	assign ad_w  = d_w[39] ? 64'(-d_w) : 64'(d_w);
	assign den_w = c_q[63] ? (65'sd1 <<< 61) + 65'(ec_mag_q)
	                       : (65'sd1 <<< 61) - 65'(ec_mag_q);
	assign rem_sh = {rem_q[62:0], cmd.div_first ? ad_q[0] : 1'b0};

	assign step  = cap_q ? STEP_CAP : {1'b0, quo_q};
	assign e_ext = 64'(e_q);
	assign e_new = d_neg_q ? e_ext + 64'(step) : e_ext - 64'(step);

	assign z_new = (64'(r_q - 35'(RED_HALF)) <<< RED_SHIFT) - kd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= mean_anomaly;
			e_q   <= mean_anomaly;
			ecc_q <= eccentricity;
		end
		if (cmd.prep) begin
			r_q  <= 35'(e_q) + 35'(RED_HALF);
			k_q  <= 4'sd0;
			kd_q <= 64'sd0;
		end
		if (cmd.red) begin
			if (r_q < 0) begin
				r_q  <= r_q + 35'(RED_H);
				k_q  <= k_q - 4'sd1;
				kd_q <= kd_q - 64'(RED_DELTA);
			end else begin
				r_q  <= r_q - 35'(RED_H);
				k_q  <= k_q + 4'sd1;
				kd_q <= kd_q + 64'(RED_DELTA);
			end
		end
		if (cmd.zinit) begin
			x_q <= GAIN_Q60;
			y_q <= 64'sd0;
			z_q <= z_new;
		end
		if (cmd.cord) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ATAN_TAB[cmd.cord_idx];
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ATAN_TAB[cmd.cord_idx];
			end
		end
		if (cmd.quad) begin
			case (k_q[1:0])
				2'd0:    begin s_q <= y_q;  c_q <= x_q;  end
				2'd1:    begin s_q <= x_q;  c_q <= -y_q; end
				2'd2:    begin s_q <= -y_q; c_q <= -x_q; end
				default: begin s_q <= -x_q; c_q <= y_q;  end
			endcase
		end
		if (cmd.mul) begin
			// even steps multiply, odd steps accumulate the previous product
			if (!cmd.mul_sel[0]) begin
				prod_q <= {32'd0, ecc_q} * mul_op;
			end else begin
				case (cmd.mul_sel[2:1])
					2'd0, 2'd2: acc_q <= {32'd0, prod_q};
					2'd1:       es_mag_q <= 33'((acc_sum + (96'd1 << 63)) >> 64);
					default:    ec_mag_q <= 63'((acc_sum + (96'd1 << 30)) >> 31);
				endcase
			end
		end
		if (cmd.resid) begin
			d_neg_q <= d_w[39];
			ad_q    <= ad_w;
			den_q   <= (den_w < 65'sd1) ? 64'd1 : 64'(den_w);
			rem_q   <= ad_w >> 1;
			cap_q   <= (ad_w >> 1) >= ((den_w < 65'sd1) ? 64'd1 : 64'(den_w));
		end
		if (cmd.div) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				quo_q <= {quo_q[60:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[60:0], 1'b0};
			end
		end
		if (cmd.upd) begin
			if (e_new > 64'sd2147483647) e_q <= 32'sh7FFFFFFF;
			else if (e_new < -64'sd2147483648) e_q <= 32'sh80000000;
			else e_q <= 32'(e_new);
		end
		if (cmd.fin) eccentric_anomaly <= e_q;
	end

	assign sts.red_done = (r_q >= 0) && (r_q < 35'(RED_H));
	assign sts.div_cap  = cap_q;
	assign sts.conv     = ad_q <= 64'(tolerance);

endmodule

/* rtl/kes_checker.sv */
module kes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid after reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled word changed");

	a_pass_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[37:32] != 6'd0)
		else $error("result with zero passes");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while busy");

endmodule

bind kepler_equation_solver kes_checker u_kes_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import kes_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // mean_anomaly[31:0], eccentricity[63:32]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // eccentric_anomaly[31:0], passes_used[37:32], zero
	logic        m_tuser;   // converged
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	kepler_equation_solver DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		logic [31:0] anomaly;
		logic [5:0]  passes;
		logic        conv;
	} solution_t;

	typedef struct {
		logic [31:0] mean;
		logic [31:0] ecc;
		bit          typed;     // expected result written in the row
		logic [31:0] anomaly;
		logic [5:0]  passes;
		logic        conv;
	} orbit_row_t;

	solution_t   pending_solutions[$];
	longint      atan_steps[64];
	logic [15:0] cur_tolerance;
	logic [5:0]  cur_max_iter;
	int          error_count;
	bit          quiet;        // no idling on either side near the end

	localparam longint H_ANG = longint'(HALF_PI_Q60 >> 32);
	localparam longint H_LOW = longint'(HALF_PI_Q60 - (64'(H_ANG) << 32));
	localparam longint ANG_HI = 64'sd2147483647;
	localparam longint ANG_LO = -64'sd2147483648;

	// atan(2^-i) in Q60 from the alternating series in Q62, rounded
	function automatic void fill_atan_steps();
		logic [63:0] acc;
		logic [63:0] term;
		int ex;
		atan_steps[0] = longint'(QUARTER_PI_Q60);
		for (int i = 1; i < 64; i++) begin
			acc = 0;
			for (int k = 0; k < 32; k++) begin
				ex = i * (2 * k + 1);
				if (ex <= 62) begin
					term = (64'd1 << (62 - ex)) / 64'(2 * k + 1);
					acc = (k % 2) ? acc - term : acc + term;
				end
			end
			atan_steps[i] = longint'((acc + 64'd2) >> 2);
		end
	endfunction

	// (a*b + half) >> sh, rounded to nearest
	function automatic logic [63:0] round_product(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (sh - 1));
		return 64'(p >> sh);
	endfunction

	function automatic void cordic_sin_cos(longint ang, output longint s, output longint c);
		longint num, k, r, z, x, y, dx, dy;
		num = ang + H_ANG / 2;
		k = num / H_ANG;
		if (num % H_ANG != 0 && num < 0) k--;
		r = ang - k * H_ANG;
		z = r * (64'sd1 <<< RED_SHIFT) - k * H_LOW;
		x = GAIN_Q60;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_steps[i];
			end else begin
				x += dx; y -= dy; z += atan_steps[i];
			end
		end
		case (k & 3)
			0: begin s = y;  c = x;  end
			1: begin s = x;  c = -y; end
			2: begin s = -y; c = -x; end
			default: begin s = -x; c = y; end
		endcase
	endfunction

	// Newton passes on E - e*sin(E) = M with the current register values
	function automatic solution_t solve_kepler(logic [31:0] mean, logic [31:0] ecc);
		solution_t   res;
		longint      m, e_anom, s, c, es, ec, d, den, stepq;
		logic [63:0] ad;
		logic [127:0] q;
		int          cap, pass;
		bit          conv;
		m = longint'(signed'(mean));
		e_anom = m;
		cap = (cur_max_iter == 0) ? 1 : int'(cur_max_iter);
		pass = 0;
		conv = 0;
		do begin
			pass++;
			cordic_sin_cos(e_anom, s, c);
			es = longint'(round_product({32'd0, ecc}, s < 0 ? -s : s, 92 - FRAC_BITS));
			if (s < 0) es = -es;
			d = e_anom - es - m;
			ec = longint'(round_product({32'd0, ecc}, c < 0 ? -c : c, 31));
			if (c < 0) ec = -ec;
			den = (64'sd1 <<< 61) - ec;
			if (den < 1) den = 1;
			ad = d < 0 ? -d : d;
			q = ({64'd0, ad} << 61) / {64'd0, den};
			stepq = (q >= (128'd1 << 62)) ? longint'(STEP_CAP) : longint'(q[63:0]);
			e_anom = (d < 0) ? e_anom + stepq : e_anom - stepq;
			if (e_anom > ANG_HI) e_anom = ANG_HI;
			if (e_anom < ANG_LO) e_anom = ANG_LO;
			if (ad <= 64'(cur_tolerance)) conv = 1;
		end while (!conv && pass < cap);
		res.anomaly = e_anom[31:0];
		res.passes = 6'(pass);
		res.conv = conv;
		return res;
	endfunction

	// directed rows: zero eccentricity leaves E = M after one pass
	orbit_row_t orbit_rows[] = '{
		'{32'h00000000, 32'h00000000, 1, 32'h00000000, 6'd1, 1'b1},
		'{32'h7FFFFFFF, 32'h00000000, 1, 32'h7FFFFFFF, 6'd1, 1'b1},
		'{32'h80000000, 32'h00000000, 1, 32'h80000000, 6'd1, 1'b1},
		'{32'hAAAAAAAA, 32'h00000000, 1, 32'hAAAAAAAA, 6'd1, 1'b1},
		'{32'h55555555, 32'h00000000, 1, 32'h55555555, 6'd1, 1'b1},
		'{32'h00000000, 32'hFFFFFFFF, 0, 0, 0, 0},
		'{32'h10000000, 32'h80000000, 0, 0, 0, 0},
		'{32'h3243F6A8, 32'hFFFFFFFF, 0, 0, 0, 0},   // near +pi
		'{32'hCDBC0958, 32'hFFFFFFFF, 0, 0, 0, 0},   // near -pi
		'{32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0},
		'{32'h80000000, 32'hFFFFFFFF, 0, 0, 0, 0},
		'{32'h00000001, 32'hFFFFFFFF, 0, 0, 0, 0},   // tiny denominator
		'{32'h40000000, 32'hFFFFFFFF, 0, 0, 0, 0},
		'{32'h55555555, 32'hAAAAAAAA, 0, 0, 0, 0},
		'{32'hAAAAAAAA, 32'h55555555, 0, 0, 0, 0},
		'{32'hFFFFFFFF, 32'h00000001, 0, 0, 0, 0}
	};

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// hold a register write until the config channel takes it
	task automatic write_register(logic [1:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_TOLERANCE) cur_tolerance = value;
		else cur_max_iter = value[5:0];
	endtask

	task automatic set_registers(logic [15:0] tol, logic [5:0] iters);
		write_register(REG_TOLERANCE, tol);
		write_register(REG_MAX_ITER, {10'd0, iters});
	endtask

	// send one word, queue its solution when taken, maybe idle afterwards
	task automatic send_word(logic [31:0] mean, logic [31:0] ecc, bit typed, solution_t typed_res);
		s_tvalid <= 1'b1;
		s_tdata  <= {ecc, mean};
		do @(posedge clk); while (!s_tready);
		pending_solutions.push_back(typed ? typed_res : solve_kepler(mean, ecc));
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_ecc();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 32'h00FFFFFF);
			1: return 32'hFFFFFFFF - $urandom_range(0, 32'h00FFFFFF);
			default: return $urandom;
		endcase
	endfunction

	// random phase with a fixed register setting
	task automatic random_phase(logic [15:0] tol, logic [5:0] iters, int count);
		solution_t none;
		set_registers(tol, iters);
		none = '{0, 0, 0};
		for (int n = 0; n < count; n++)
			send_word($urandom, pick_ecc(), 0, none);
		drain();
	endtask

	// receiver stalls in bursts
	always @(posedge clk or negedge arst_n) begin : ready_gen
		int hold;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold = 0;
		end else if (!quiet && hold > 0) begin
			hold--;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			hold = $urandom_range(0, 12);
		end else begin
			m_tready <= 1'b1;
			hold = $urandom_range(0, 20);
		end
	end

	// compare each word taken from the block with the oldest expectation
	always @(posedge clk) begin : result_check
		solution_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_solutions.size() == 0) begin
				$error("result word with no expectation: %h", m_tdata);
				error_count++;
			end else begin
				want = pending_solutions.pop_front();
				if (m_tdata[31:0] !== want.anomaly) begin
					$error("eccentric_anomaly expected %h got %h", want.anomaly, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[37:32] !== want.passes) begin
					$error("passes_used expected %0d got %0d", want.passes, m_tdata[37:32]);
					error_count++;
				end
				if (m_tuser !== want.conv) begin
					$error("converged expected %b got %b", want.conv, m_tuser);
					error_count++;
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		solution_t typed_res;
		error_count = 0;
		quiet = 0;
		cur_tolerance = 16'd268;
		cur_max_iter = 6'd16;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		arst_n = 0;
		fill_atan_steps();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings, then at zero tolerance and zero cap
		foreach (orbit_rows[i]) begin
			typed_res = '{orbit_rows[i].anomaly, orbit_rows[i].passes, orbit_rows[i].conv};
			send_word(orbit_rows[i].mean, orbit_rows[i].ecc, orbit_rows[i].typed, typed_res);
		end
		drain();
		set_registers(16'd0, 6'd0);
		for (int i = 0; i < 8; i++)
			send_word(orbit_rows[i].mean, orbit_rows[i].ecc, 0, typed_res);
		drain();

		// random phases over several settings, extremes among them
		random_phase(16'd268, 6'd16, 300);
		random_phase(16'd1, 6'd1, 250);
		random_phase(16'hFFFF, 6'd63, 200);
		random_phase(16'd0, 6'd8, 150);
		random_phase(16'd1, 6'd63, 60);
		random_phase(16'hAAAA, 6'd21, 200);
		random_phase(16'h5555, 6'd42, 150);
		random_phase(16'd3, 6'd5, 250);
		quiet = 1;
		random_phase(16'd268, 6'd12, 280);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
